// ===== hdl/glos_pkg.sv =====
// shared constants, codes and types of the grid line-of-sight checker
package glos_pkg;

	localparam int MAX_COLUMNS = 256;
	localparam int MAX_ROWS    = 256;
	localparam int GRID_DEPTH  = MAX_COLUMNS * MAX_ROWS;
	localparam int ADDR_W      = $clog2(GRID_DEPTH);

	localparam int COORD_W     = 8;
	localparam int COST_W      = 8;
	localparam int DIM_W       = 9;
	localparam int CFG_INDEX_W = 2;
	localparam int CFG_DATA_W  = 9;

	localparam logic [CFG_INDEX_W-1:0] CFG_GRID_WIDTH       = 2'd0;
	localparam logic [CFG_INDEX_W-1:0] CFG_GRID_HEIGHT      = 2'd1;
	localparam logic [CFG_INDEX_W-1:0] CFG_LETHAL_THRESHOLD = 2'd2;

	localparam logic [DIM_W-1:0]  RESET_GRID_WIDTH       = 9'd256;
	localparam logic [DIM_W-1:0]  RESET_GRID_HEIGHT      = 9'd256;
	localparam logic [COST_W-1:0] RESET_LETHAL_THRESHOLD = 8'd253;

	localparam logic ACT_WRITE = 1'b0;
	localparam logic ACT_QUERY = 1'b1;

	typedef enum logic [2:0] {
		W_IDLE,
		W_STEP,
		W_T1,
		W_T2,
		W_PA,
		W_PB,
		W_DONE
	} walk_state_t;

	typedef struct packed {
		logic [DIM_W-1:0]  grid_width;
		logic [DIM_W-1:0]  grid_height;
		logic [COST_W-1:0] lethal_threshold;
	} cfg_t;

	typedef struct packed {
		logic [COORD_W-1:0] start_x;
		logic [COORD_W-1:0] start_y;
		logic [COORD_W-1:0] end_x;
		logic [COORD_W-1:0] end_y;
	} query_t;

	typedef struct packed {
		logic idle;
		logic done;
		logic clear;
	} walk_status_t;

	typedef struct packed {
		logic              en;
		logic [ADDR_W-1:0] addr;
		logic [COST_W-1:0] data;
	} ram_wr_t;

	typedef struct packed {
		logic              en;
		logic [ADDR_W-1:0] addr;
	} ram_rd_t;

endpackage

// ===== hdl/grid_line_of_sight_check_core.sv =====
// top level: configuration, cell writes, clearing pass, walker and result register
// a write transaction is stored when it is accepted; a query is walked one major-axis
// step at a time, each step reading its probed cells from the store, and its result is
// then taken into the result register; one item is worked on at a time, the result
// register lets the next in; after reset a clearing pass writes zero to all 65536 cells,
// one a cycle; no transaction is taken meanwhile, configuration writes still are
module grid_line_of_sight_check_core (
	input  logic                             clk,
	input  logic                             arst_n,
	input  logic                             cfg_we,
	input  logic [glos_pkg::CFG_INDEX_W-1:0] cfg_index,
	input  logic [glos_pkg::CFG_DATA_W-1:0]  cfg_data,
	input  logic                             in_valid,
	output logic                             in_ready,
	input  logic                             action,
	input  logic [glos_pkg::COORD_W-1:0]     start_x,
	input  logic [glos_pkg::COORD_W-1:0]     start_y,
	input  logic [glos_pkg::COORD_W-1:0]     end_x,
	input  logic [glos_pkg::COORD_W-1:0]     end_y,
	input  logic [glos_pkg::COST_W-1:0]      cell_cost,
	output logic                             out_valid,
	input  logic                             out_ready,
	output logic                             line_clear
);

	glos_pkg::cfg_t          cfg_q;
	glos_pkg::query_t        query;
	glos_pkg::walk_status_t  walk_status;
	glos_pkg::ram_wr_t       ram_wr;
	glos_pkg::ram_rd_t       ram_rd;

	logic [glos_pkg::COST_W-1:0] rd_data;
	logic [glos_pkg::ADDR_W-1:0] clr_addr_q;
	logic                        clearing_q;
	logic                        out_valid_q, line_clear_q;
	logic                        accept, item_write, item_query, in_store, ack;
	logic [31:0]                 wr_lin;

	// configuration registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.grid_width       <= glos_pkg::RESET_GRID_WIDTH;
			cfg_q.grid_height      <= glos_pkg::RESET_GRID_HEIGHT;
			cfg_q.lethal_threshold <= glos_pkg::RESET_LETHAL_THRESHOLD;
		end else if (cfg_we) begin
			unique case (cfg_index)
				glos_pkg::CFG_GRID_WIDTH:       cfg_q.grid_width <= cfg_data;
				glos_pkg::CFG_GRID_HEIGHT:      cfg_q.grid_height <= cfg_data;
				glos_pkg::CFG_LETHAL_THRESHOLD: begin
					cfg_q.lethal_threshold <= cfg_data[glos_pkg::COST_W-1:0];
				end
				default: begin
				end
			endcase
		end
	end

	// clearing pass
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			clearing_q <= 1'b1;
			clr_addr_q <= '0;
		end else if (clearing_q) begin
			clr_addr_q <= clr_addr_q + 1'b1;
			if (32'(clr_addr_q) == 32'(glos_pkg::GRID_DEPTH - 1)) begin
				clearing_q <= 1'b0;
			end
		end
	end

	assign in_ready   = !clearing_q && walk_status.idle;
	assign accept     = in_valid && in_ready;
	assign item_write = accept && (action == glos_pkg::ACT_WRITE);
	assign item_query = accept && (action == glos_pkg::ACT_QUERY);

	always_comb begin
		in_store = (32'(start_x) < 32'(glos_pkg::MAX_COLUMNS))
		        && (32'(start_y) < 32'(glos_pkg::MAX_ROWS));
		wr_lin   = 32'(start_y) * 32'(glos_pkg::MAX_COLUMNS) + 32'(start_x);
		if (clearing_q) begin
			ram_wr.en   = 1'b1;
			ram_wr.addr = clr_addr_q;
			ram_wr.data = '0;
		end else begin
			ram_wr.en   = item_write && in_store;
			ram_wr.addr = wr_lin[glos_pkg::ADDR_W-1:0];
			ram_wr.data = cell_cost;
		end
	end

	assign query.start_x = start_x;
	assign query.start_y = start_y;
	assign query.end_x   = end_x;
	assign query.end_y   = end_y;

	glos_grid_ram u_ram (
		.clk     (clk),
		.wr      (ram_wr),
		.rd      (ram_rd),
		.rd_data (rd_data)
	);

	glos_walker u_walker (
		.clk     (clk),
		.arst_n  (arst_n),
		.start   (item_query),
		.query   (query),
		.ack     (ack),
		.cfg     (cfg_q),
		.rd_data (rd_data),
		.rd      (ram_rd),
		.status  (walk_status)
	);

	// result register
	assign ack = walk_status.done && (!out_valid_q || out_ready);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (ack) begin
			out_valid_q <= 1'b1;
		end else if (out_ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (ack) begin
			line_clear_q <= walk_status.clear;
		end
	end

	assign out_valid  = out_valid_q;
	assign line_clear = line_clear_q;

	a_query_busy: assert property (@(posedge clk) disable iff (!arst_n)
		item_query |=> !in_ready)
		else $error("walker did not go busy after a query transaction");

	a_result_held: assert property (@(posedge clk) disable iff (!arst_n)
		walk_status.done && !ack |=> walk_status.done && $stable(walk_status.clear))
		else $error("walker result lost before the result register took it");

	a_no_read_clearing: assert property (@(posedge clk) disable iff (!arst_n)
		clearing_q |-> !ram_rd.en)
		else $error("store read during the clearing pass");

endmodule

// ===== hdl/glos_grid_ram.sv =====
// cell cost store: one write port, one registered read port
module glos_grid_ram (
	input  logic                       clk,
	input  glos_pkg::ram_wr_t          wr,
	input  glos_pkg::ram_rd_t          rd,
	output logic [glos_pkg::COST_W-1:0] rd_data
);

	logic [glos_pkg::COST_W-1:0] mem [glos_pkg::GRID_DEPTH];

	always_ff @(posedge clk) begin
		if (wr.en) begin
			mem[wr.addr] <= wr.data;
		end
	end

	always_ff @(posedge clk) begin
		if (rd.en) begin
			rd_data <= mem[rd.addr];
		end
	end

endmodule

// ===== hdl/glos_walker.sv =====
// line walker: steps along the major axis and probes the crossed cells in the store
module glos_walker (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic                        start,
	input  glos_pkg::query_t            query,
	input  logic                        ack,
	input  glos_pkg::cfg_t              cfg,
	input  logic [glos_pkg::COST_W-1:0] rd_data,
	output glos_pkg::ram_rd_t           rd,
	output glos_pkg::walk_status_t      status
);

	localparam int CW = glos_pkg::COORD_W;

	glos_pkg::walk_state_t state_q, state_d;

	logic [CW-1:0] maj_q, maj_d, min_q, min_d;
	logic [CW-1:0] end_maj_q, dmaj_q, dmin_q;
	logic [CW:0]   acc_q, acc_d;
	logic          xmaj_q, smaj_neg_q, smin_neg_q;
	logic          clear_q, clear_d;
	logic          in_grid_s1;

	logic [CW-1:0] dx, dy;
	logic          xmaj;

	logic [CW:0]   acc_sum, acc_next;
	logic          crossed;
	logic [CW-1:0] maj_step, min_next;
	logic [CW:0]   maj_off, min_off, min_next_off, min_m1;

	logic          probe_en;
	logic [CW:0]   probe_min, px, py;
	logic          in_grid;
	logic [31:0]   lin_addr;
	logic          safe;

	// start decode
	always_comb begin
		dx   = (query.end_x > query.start_x) ? query.end_x - query.start_x
		                                     : query.start_x - query.end_x;
		dy   = (query.end_y > query.start_y) ? query.end_y - query.start_y
		                                     : query.start_y - query.end_y;
		xmaj = (dx >= dy);
	end

	// step arithmetic
	always_comb begin
		acc_sum      = acc_q + {1'b0, dmin_q};
		crossed      = (acc_sum >= {1'b0, dmaj_q});
		acc_next     = crossed ? acc_sum - {1'b0, dmaj_q} : acc_sum;
		maj_step     = smaj_neg_q ? maj_q - 1'b1 : maj_q + 1'b1;
		min_next     = smin_neg_q ? min_q - 1'b1 : min_q + 1'b1;
		maj_off      = {1'b0, maj_q} - {{CW{1'b0}}, smaj_neg_q};
		min_off      = {1'b0, min_q} - {{CW{1'b0}}, smin_neg_q};
		min_next_off = {1'b0, min_next} - {{CW{1'b0}}, smin_neg_q};
		min_m1       = {1'b0, min_q} - {{CW{1'b0}}, 1'b1};
	end

	assign safe = in_grid_s1 && (rd_data < cfg.lethal_threshold);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= glos_pkg::W_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	always_ff @(posedge clk) begin
		maj_q      <= maj_d;
		min_q      <= min_d;
		acc_q      <= acc_d;
		clear_q    <= clear_d;
		in_grid_s1 <= in_grid;
		if (state_q == glos_pkg::W_IDLE && start) begin
			xmaj_q     <= xmaj;
			end_maj_q  <= xmaj ? query.end_x : query.end_y;
			dmaj_q     <= xmaj ? dx : dy;
			dmin_q     <= xmaj ? dy : dx;
			smaj_neg_q <= xmaj ? !(query.end_x > query.start_x)
			                   : !(query.end_y > query.start_y);
			smin_neg_q <= xmaj ? !(query.end_y > query.start_y)
			                   : !(query.end_x > query.start_x);
		end
	end

	always_comb begin
		state_d   = state_q;
		maj_d     = maj_q;
		min_d     = min_q;
		acc_d     = acc_q;
		clear_d   = clear_q;
		probe_en  = 1'b0;
		probe_min = min_off;
		unique case (state_q)
			glos_pkg::W_IDLE: begin
				maj_d = xmaj ? query.start_x : query.start_y;
				min_d = xmaj ? query.start_y : query.start_x;
				acc_d = '0;
				if (start) begin
					state_d = glos_pkg::W_STEP;
				end
			end
			glos_pkg::W_STEP: begin
				if (maj_q == end_maj_q) begin
					clear_d = 1'b1;
					state_d = glos_pkg::W_DONE;
				end else if (dmin_q == '0) begin
					// axis-aligned: test the two side cells
					probe_en  = 1'b1;
					probe_min = {1'b0, min_q};
					state_d   = glos_pkg::W_PA;
				end else begin
					acc_d = acc_next;
					if (crossed) begin
						probe_en = 1'b1;
						state_d  = glos_pkg::W_T1;
					end else if (acc_next != '0) begin
						probe_en = 1'b1;
						state_d  = glos_pkg::W_T2;
					end else begin
						maj_d = maj_step;
					end
				end
			end
			glos_pkg::W_T1: begin
				if (!safe) begin
					clear_d = 1'b0;
					state_d = glos_pkg::W_DONE;
				end else begin
					min_d = min_next;
					if (acc_q != '0) begin
						probe_en  = 1'b1;
						probe_min = min_next_off;
						state_d   = glos_pkg::W_T2;
					end else begin
						maj_d   = maj_step;
						state_d = glos_pkg::W_STEP;
					end
				end
			end
			glos_pkg::W_T2, glos_pkg::W_PB: begin
				if (!safe) begin
					clear_d = 1'b0;
					state_d = glos_pkg::W_DONE;
				end else begin
					maj_d   = maj_step;
					state_d = glos_pkg::W_STEP;
				end
			end
			glos_pkg::W_PA: begin
				if (safe) begin
					maj_d   = maj_step;
					state_d = glos_pkg::W_STEP;
				end else begin
					probe_en  = 1'b1;
					probe_min = min_m1;
					state_d   = glos_pkg::W_PB;
				end
			end
			glos_pkg::W_DONE: begin
				if (ack) begin
					state_d = glos_pkg::W_IDLE;
				end
			end
			default: begin
				state_d = glos_pkg::W_IDLE;
			end
		endcase
	end

	// probe address and grid bounds
	always_comb begin
		px       = xmaj_q ? maj_off : probe_min;
		py       = xmaj_q ? probe_min : maj_off;
		in_grid  = !px[CW] && !py[CW]
		        && ({1'b0, px[CW-1:0]} < cfg.grid_width)
		        && ({1'b0, py[CW-1:0]} < cfg.grid_height)
		        && (32'(px[CW-1:0]) < 32'(glos_pkg::MAX_COLUMNS))
		        && (32'(py[CW-1:0]) < 32'(glos_pkg::MAX_ROWS));
		lin_addr = 32'(py[CW-1:0]) * 32'(glos_pkg::MAX_COLUMNS) + 32'(px[CW-1:0]);
		rd.en    = probe_en;
		rd.addr  = in_grid ? lin_addr[glos_pkg::ADDR_W-1:0] : '0;
	end

	assign status.idle  = (state_q == glos_pkg::W_IDLE);
	assign status.done  = (state_q == glos_pkg::W_DONE);
	assign status.clear = clear_q;

endmodule

// ===== tb/sv/tb_grid_line_of_sight_check_core.sv =====
`timescale 1ns / 1ps
// self-checking testbench for the grid line-of-sight checker: register settings, cell writes and queries
module tb_grid_line_of_sight_check_core;

	localparam int LIMIT_CYCLES  = 4_000_000;
	localparam int HOLD_CYCLES   = 3000;
	localparam int DRAIN_CYCLES  = 800;
	localparam int SETTLE_CYCLES = 16;

	typedef enum int {
		RX_FREE,
		RX_COIN,
		RX_SPARSE,
		RX_RHYTHM
	} rx_mode_t;

	typedef struct packed {
		logic                        action;
		glos_pkg::query_t            pts;
		logic [glos_pkg::COST_W-1:0] cost;
	} los_item_t;

	class los_tracker;
		logic [glos_pkg::COST_W-1:0] cost_grid [glos_pkg::GRID_DEPTH];
		logic [glos_pkg::DIM_W-1:0]  grid_w;
		logic [glos_pkg::DIM_W-1:0]  grid_h;
		logic [glos_pkg::COST_W-1:0] lethal;
		bit                          pending_clear [$];
		int unsigned                 mismatches;
		int unsigned                 writes_seen;
		int unsigned                 queries_seen;
		int unsigned                 clear_seen;
		int unsigned                 blocked_seen;

		function new();
			foreach (cost_grid[i])
				cost_grid[i] = '0;
			grid_w       = glos_pkg::RESET_GRID_WIDTH;
			grid_h       = glos_pkg::RESET_GRID_HEIGHT;
			lethal       = glos_pkg::RESET_LETHAL_THRESHOLD;
			mismatches   = 0;
			writes_seen  = 0;
			queries_seen = 0;
			clear_seen   = 0;
			blocked_seen = 0;
		endfunction

		function void set_reg(logic [glos_pkg::CFG_INDEX_W-1:0] idx,
			logic [glos_pkg::CFG_DATA_W-1:0] val);
			case (idx)
				glos_pkg::CFG_GRID_WIDTH:       grid_w = val;
				glos_pkg::CFG_GRID_HEIGHT:      grid_h = val;
				glos_pkg::CFG_LETHAL_THRESHOLD: lethal = val[glos_pkg::COST_W-1:0];
				default: ;
			endcase
		endfunction

		function void queue_expect(bit want);
			pending_clear = {pending_clear, want};
		endfunction

		function bit cell_ok(int x, int y);
			int w;
			int h;
			w = (grid_w < glos_pkg::MAX_COLUMNS) ? int'(grid_w) : glos_pkg::MAX_COLUMNS;
			h = (grid_h < glos_pkg::MAX_ROWS) ? int'(grid_h) : glos_pkg::MAX_ROWS;
			if (x < 0 || y < 0 || x >= w || y >= h)
				return 1'b0;
			return cost_grid[y * glos_pkg::MAX_COLUMNS + x] < lethal;
		endfunction

		function bit walk_line_clear(int x0, int y0, int x1, int y1);
			int dx;
			int dy;
			int sx;
			int sy;
			int ox;
			int oy;
			int cx;
			int cy;
			int acc;
			dx  = (x1 > x0) ? x1 - x0 : x0 - x1;
			dy  = (y1 > y0) ? y1 - y0 : y0 - y1;
			sx  = (x1 > x0) ? 1 : -1;
			sy  = (y1 > y0) ? 1 : -1;
			ox  = (sx > 0) ? 0 : -1;
			oy  = (sy > 0) ? 0 : -1;
			cx  = x0;
			cy  = y0;
			acc = 0;
			if (dx >= dy) begin
				while (cx != x1) begin
					acc += dy;
					if (acc >= dx) begin
						if (!cell_ok(cx + ox, cy + oy))
							return 1'b0;
						cy  += sy;
						acc -= dx;
					end
					if (acc != 0 && !cell_ok(cx + ox, cy + oy))
						return 1'b0;
					// axis-aligned: blocked only when both neighbouring rows are unsafe
					if (dy == 0 && !cell_ok(cx + ox, cy) && !cell_ok(cx + ox, cy - 1))
						return 1'b0;
					cx += sx;
				end
			end else begin
				while (cy != y1) begin
					acc += dx;
					if (acc >= dy) begin
						if (!cell_ok(cx + ox, cy + oy))
							return 1'b0;
						cx  += sx;
						acc -= dy;
					end
					if (acc != 0 && !cell_ok(cx + ox, cy + oy))
						return 1'b0;
					if (dx == 0 && !cell_ok(cx, cy + oy) && !cell_ok(cx - 1, cy + oy))
						return 1'b0;
					cy += sy;
				end
			end
			return 1'b1;
		endfunction

		function void note_input(los_item_t it);
			if (it.action == glos_pkg::ACT_WRITE) begin
				writes_seen++;
				if (it.pts.start_x < glos_pkg::MAX_COLUMNS && it.pts.start_y < glos_pkg::MAX_ROWS)
					cost_grid[int'(it.pts.start_y) * glos_pkg::MAX_COLUMNS
						+ int'(it.pts.start_x)] = it.cost;
			end else begin
				queries_seen++;
				queue_expect(walk_line_clear(int'(it.pts.start_x), int'(it.pts.start_y),
					int'(it.pts.end_x), int'(it.pts.end_y)));
			end
		endfunction

		function void check_result(logic got);
			bit want;
			if (pending_clear.size() == 0) begin
				mismatches++;
				if (mismatches <= 10)
					$display("unexpected result line_clear=%b at %0t", got, $time);
				return;
			end
			want = pending_clear.pop_front();
			if (got === 1'b1)
				clear_seen++;
			else
				blocked_seen++;
			if (got !== want) begin
				mismatches++;
				if (mismatches <= 10)
					$display("line_clear mismatch: expected %b, actual %b at %0t",
						want, got, $time);
			end
		endfunction
	endclass

	logic                             clk;
	logic                             arst_n;
	logic                             cfg_we;
	logic [glos_pkg::CFG_INDEX_W-1:0] cfg_index;
	logic [glos_pkg::CFG_DATA_W-1:0]  cfg_data;
	logic                             in_valid;
	logic                             in_ready;
	logic                             action;
	logic [glos_pkg::COORD_W-1:0]     start_x;
	logic [glos_pkg::COORD_W-1:0]     start_y;
	logic [glos_pkg::COORD_W-1:0]     end_x;
	logic [glos_pkg::COORD_W-1:0]     end_y;
	logic [glos_pkg::COST_W-1:0]      cell_cost;
	logic                             out_valid;
	logic                             out_ready = 1'b0;
	logic                             line_clear;

	los_tracker  tracker;
	int unsigned cycle_count = 0;
	int unsigned phases_run = 0;
	bit          hold_go = 1'b0;
	int unsigned hold_left = 0;
	int unsigned mode_left = 0;
	rx_mode_t    rx_mode = RX_FREE;

	grid_line_of_sight_check_core uut (
		.clk        (clk),
		.arst_n     (arst_n),
		.cfg_we     (cfg_we),
		.cfg_index  (cfg_index),
		.cfg_data   (cfg_data),
		.in_valid   (in_valid),
		.in_ready   (in_ready),
		.action     (action),
		.start_x    (start_x),
		.start_y    (start_y),
		.end_x      (end_x),
		.end_y      (end_y),
		.cell_cost  (cell_cost),
		.out_valid  (out_valid),
		.out_ready  (out_ready),
		.line_clear (line_clear)
	);

	initial clk = 1'b0;
	always #5 clk = ~clk;

	always @(posedge clk) begin
		cycle_count++;
		if (cycle_count >= LIMIT_CYCLES) begin
			$display("tb_grid_line_of_sight_check_core failed");
			$finish;
		end
	end

	// receiver stall pattern, with one long hold-off on request
	always @(posedge clk) begin
		if (hold_go) begin
			hold_go   = 1'b0;
			hold_left = HOLD_CYCLES;
		end
		if (mode_left == 0) begin
			rx_mode   = rx_mode_t'($urandom_range(0, 3));
			mode_left = $urandom_range(64, 512);
		end else begin
			mode_left--;
		end
		if (hold_left != 0) begin
			hold_left--;
			out_ready <= 1'b0;
		end else begin
			case (rx_mode)
				RX_FREE:   out_ready <= 1'b1;
				RX_COIN:   out_ready <= ($urandom_range(0, 1) == 1);
				RX_SPARSE: out_ready <= ($urandom_range(0, 3) == 0);
				default:   out_ready <= (cycle_count[1:0] != 2'b00);
			endcase
		end
	end

	always @(posedge clk)
		if (arst_n === 1'b1 && out_valid === 1'b1 && out_ready === 1'b1)
			tracker.check_result(line_clear);

	function automatic int pick_coord(int dim);
		int r;
		int hi;
		r  = $urandom_range(0, 99);
		hi = (dim > 255) ? 255 : dim;
		if (r < 4)
			return $urandom_range(0, 255);
		if (r < 12)
			return (hi + 3 > 255) ? 255 : hi + $urandom_range(1, 3);
		return $urandom_range(0, hi);
	endfunction

	function automatic los_item_t make_write(int x, int y, int c);
		los_item_t it;
		int        filler;
		filler         = $urandom;
		it.action      = glos_pkg::ACT_WRITE;
		it.pts.start_x = x[glos_pkg::COORD_W-1:0];
		it.pts.start_y = y[glos_pkg::COORD_W-1:0];
		it.pts.end_x   = filler[glos_pkg::COORD_W-1:0];
		it.pts.end_y   = filler[2*glos_pkg::COORD_W-1:glos_pkg::COORD_W];
		it.cost        = c[glos_pkg::COST_W-1:0];
		return it;
	endfunction

	function automatic los_item_t make_query(int x0, int y0, int x1, int y1);
		los_item_t it;
		int        filler;
		filler         = $urandom;
		it.action      = glos_pkg::ACT_QUERY;
		it.pts.start_x = x0[glos_pkg::COORD_W-1:0];
		it.pts.start_y = y0[glos_pkg::COORD_W-1:0];
		it.pts.end_x   = x1[glos_pkg::COORD_W-1:0];
		it.pts.end_y   = y1[glos_pkg::COORD_W-1:0];
		it.cost        = filler[glos_pkg::COST_W-1:0];
		return it;
	endfunction

	function automatic los_item_t random_item(int gw, int gh, int thr);
		los_item_t it;
		int        r;
		int        c;
		if ($urandom_range(0, 1) == 0) begin
			r = $urandom_range(0, 99);
			if (r < 60 && thr > 0)
				c = $urandom_range(0, thr - 1);
			else if (r < 80)
				c = thr + $urandom_range(0, 2) - 1;
			else
				c = $urandom_range(0, 255);
			c  = (c < 0) ? 0 : (c > 255) ? 255 : c;
			it = make_write(pick_coord(gw), pick_coord(gh), c);
		end else begin
			it = make_query(pick_coord(gw), pick_coord(gh), pick_coord(gw), pick_coord(gh));
			r  = $urandom_range(0, 99);
			if (r < 20)
				it.pts.end_y = it.pts.start_y;
			else if (r < 40)
				it.pts.end_x = it.pts.start_x;
			else if (r < 45)
				it.pts = {it.pts.start_x, it.pts.start_y, it.pts.start_x, it.pts.start_y};
		end
		return it;
	endfunction

	task automatic send_item(los_item_t it);
		in_valid  <= 1'b1;
		action    <= it.action;
		start_x   <= it.pts.start_x;
		start_y   <= it.pts.start_y;
		end_x     <= it.pts.end_x;
		end_y     <= it.pts.end_y;
		cell_cost <= it.cost;
		do
			@(posedge clk);
		while (in_ready !== 1'b1);
		tracker.note_input(it);
	endtask

	task automatic write_reg(logic [glos_pkg::CFG_INDEX_W-1:0] idx,
		logic [glos_pkg::CFG_DATA_W-1:0] val);
		cfg_we    <= 1'b1;
		cfg_index <= idx;
		cfg_data  <= val;
		@(posedge clk);
		tracker.set_reg(idx, val);
	endtask

	task automatic wait_drained();
		while (tracker.pending_clear.size() != 0)
			@(posedge clk);
		repeat (SETTLE_CYCLES) @(posedge clk);
	endtask

	task automatic run_phase(int w, int h, int thr, int n_items, bit with_hold);
		int        eff_w;
		int        eff_h;
		int        burst;
		int        gap;
		int        sent;
		logic      pad;
		los_item_t it;
		wait_drained();
		pad = ($urandom_range(0, 1) == 1);
		write_reg(glos_pkg::CFG_GRID_WIDTH, w[glos_pkg::DIM_W-1:0]);
		write_reg(glos_pkg::CFG_GRID_HEIGHT, h[glos_pkg::DIM_W-1:0]);
		write_reg(glos_pkg::CFG_LETHAL_THRESHOLD, {pad, thr[glos_pkg::COST_W-1:0]});
		cfg_we <= 1'b0;
		phases_run++;
		eff_w = (w > glos_pkg::MAX_COLUMNS) ? glos_pkg::MAX_COLUMNS : w;
		eff_h = (h > glos_pkg::MAX_ROWS) ? glos_pkg::MAX_ROWS : h;
		if (with_hold)
			hold_go = 1'b1;
		sent = 0;
		while (sent < n_items) begin
			burst = $urandom_range(1, 40);
			while (burst != 0 && sent < n_items) begin
				it = random_item(eff_w, eff_h, thr);
				send_item(it);
				sent++;
				burst--;
			end
			gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 20);
			if (gap != 0) begin
				in_valid <= 1'b0;
				repeat (gap) @(posedge clk);
			end
		end
		in_valid <= 1'b0;
	endtask

	initial begin
		tracker = new();
		arst_n    <= 1'b0;
		cfg_we    <= 1'b0;
		cfg_index <= '0;
		cfg_data  <= '0;
		in_valid  <= 1'b0;
		action    <= glos_pkg::ACT_WRITE;
		start_x   <= '0;
		start_y   <= '0;
		end_x     <= '0;
		end_y     <= '0;
		cell_cost <= '0;
		repeat (9) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// directed part on the reset settings
		send_item(make_query(0, 0, 0, 0));
		send_item(make_query(0, 0, 255, 255));
		send_item(make_query(255, 255, 0, 0));
		send_item(make_query(255, 0, 0, 255));
		send_item(make_query(0, 255, 255, 0));
		send_item(make_write(10, 5, 253));
		send_item(make_write(11, 5, 252));
		send_item(make_query(9, 5, 13, 5));
		send_item(make_write(10, 4, 255));
		send_item(make_query(9, 5, 13, 5));
		send_item(make_query(13, 5, 9, 5));
		send_item(make_query(0, 0, 0, 20));
		send_item(make_write(0, 3, 254));
		send_item(make_query(0, 20, 0, 0));
		send_item(make_query(0, 0, 50, 0));
		send_item(make_query(3, 0, 5, 200));
		send_item(make_query(0, 7, 200, 9));
		send_item(make_write(255, 255, 255));
		send_item(make_query(250, 250, 255, 255));
		send_item(make_write(10, 5, 0));
		send_item(make_query(8, 3, 14, 7));
		send_item(make_write(255, 0, 128));
		send_item(make_query(255, 255, 255, 255));
		in_valid <= 1'b0;

		run_phase(8, 8, 128, 150, 1'b0);
		run_phase(16, 12, 200, 200, 1'b1);
		run_phase(1, 1, 1, 40, 1'b0);
		run_phase(0, 6, 100, 40, 1'b0);
		run_phase(7, 0, 180, 30, 1'b0);
		run_phase(511, 300, 255, 50, 1'b0);
		run_phase(24, 24, 0, 50, 1'b0);
		run_phase(5, 40, 250, 150, 1'b0);
		run_phase(256, 256, 253, 60, 1'b0);
		repeat (4)
			run_phase($urandom_range(1, 32), $urandom_range(1, 32), $urandom_range(1, 255),
				100, 1'b0);

		while (tracker.pending_clear.size() != 0)
			@(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);

		$display("run covered %0d cell writes and %0d queries over %0d register settings",
			tracker.writes_seen, tracker.queries_seen, phases_run);
		$display("queries answered clear %0d, blocked %0d, mismatches %0d",
			tracker.clear_seen, tracker.blocked_seen, tracker.mismatches);
		if (tracker.mismatches == 0 && tracker.pending_clear.size() == 0)
			$display("tb_grid_line_of_sight_check_core passed");
		else
			$display("tb_grid_line_of_sight_check_core failed");
		$finish;
	end

endmodule

// ===== sim.f =====
hdl/glos_pkg.sv
hdl/glos_grid_ram.sv
hdl/glos_walker.sv
hdl/grid_line_of_sight_check_core.sv
tb/sv/tb_grid_line_of_sight_check_core.sv
